[sv/rglw_pkg.sv]
package rglw_pkg;

  localparam int unsigned ID_W = 22;
  localparam int unsigned RANK_W = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned TABLE_ENTRIES_DEF = 4194304;
  localparam int unsigned STEP_LIMIT_DEF = 256;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [ID_W-1:0] ROOT_ID = ID_W'(1);
  localparam logic [ID_W-1:0] NO_PARENT = ID_W'(0);
  localparam logic [RANK_W-1:0] NO_RANK = RANK_W'(0);

  typedef logic [ID_W-1:0] id_t;
  typedef logic [RANK_W-1:0] rank_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_PARENT = 2'd1,
    ST_TIMEOUT   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CHECK,
    BK_STEP
  } bk_state_t;

  typedef struct packed {
    id_t   parent;
    rank_t rank;
  } entry_t;

  typedef struct packed {
    cmd_t  cmd;
    logic  wr_ok;
    id_t   node_a;
    id_t   node_b;
    id_t   parent;
    rank_t rank;
  } item_t;

  typedef struct packed {
    logic  we;
    id_t   waddr;
    entry_t wdata;
  } tbl_wr_t;

  function automatic logic in_table(input id_t id, input int unsigned entries);
    in_table = (32'(id) < entries);
  endfunction

endpackage

[sv/rglw_if.sv]
interface rglw_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [rglw_pkg::ID_W-1:0]    node_a;
  logic [rglw_pkg::ID_W-1:0]    node_b;
  logic [rglw_pkg::ID_W-1:0]    parent_in;
  logic [rglw_pkg::RANK_W-1:0]  rank_in;

  modport source (output valid, cmd, node_a, node_b, parent_in, rank_in, input ready);
  modport sink (input valid, cmd, node_a, node_b, parent_in, rank_in, output ready);
endinterface

interface rglw_out_if;
  logic                          valid;
  logic                          ready;
  logic [rglw_pkg::ID_W-1:0]     ancestor;
  logic [rglw_pkg::STATUS_W-1:0] status;

  modport source (output valid, ancestor, status, input ready);
  modport sink (input valid, ancestor, status, output ready);
endinterface

[sv/rglw_front.sv]
module rglw_front #(
  parameter int unsigned TABLE_ENTRIES = rglw_pkg::TABLE_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  rglw_pkg::item_t  in_item,
  output logic             q_valid,
  input  logic             q_pop,
  output rglw_pkg::item_t  q_item
);

  localparam int unsigned PTR_W = $clog2(rglw_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(rglw_pkg::QUEUE_DEPTH + 1);

  rglw_pkg::item_t slot_r [rglw_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  rglw_pkg::item_t  classified;
  logic             push;
  logic             pop;

  always_comb begin
    classified = in_item;
    classified.wr_ok = (in_item.cmd == rglw_pkg::CMD_WRITE) &&
                       rglw_pkg::in_table(in_item.node_a, TABLE_ENTRIES);
  end

  assign in_ready = (cnt_r != CNT_W'(rglw_pkg::QUEUE_DEPTH));
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != '0);
  assign pop = q_pop && q_valid;
  assign q_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = CNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= classified;
    end
  end

endmodule

[sv/rglw_table.sv]
module rglw_table #(
  parameter int unsigned TABLE_ENTRIES = rglw_pkg::TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  rglw_pkg::tbl_wr_t  wr,
  input  rglw_pkg::id_t      raddr_a,
  input  rglw_pkg::id_t      raddr_b,
  output rglw_pkg::entry_t   rdata_a,
  output rglw_pkg::entry_t   rdata_b
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  rglw_pkg::entry_t mem [TABLE_ENTRIES];
  rglw_pkg::entry_t rdata_a_r;
  rglw_pkg::entry_t rdata_b_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[IDX_W'(wr.waddr)] <= wr.wdata;
    end
    rdata_a_r <= mem[IDX_W'(raddr_a)];
    rdata_b_r <= mem[IDX_W'(raddr_b)];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

[sv/rglw_back.sv]
module rglw_back #(
  parameter int unsigned TABLE_ENTRIES = rglw_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned STEP_LIMIT = rglw_pkg::STEP_LIMIT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_pop,
  input  rglw_pkg::item_t     q_item,
  output rglw_pkg::tbl_wr_t   tbl_wr,
  output rglw_pkg::id_t       raddr_a,
  output rglw_pkg::id_t       raddr_b,
  input  rglw_pkg::entry_t    rdata_a,
  input  rglw_pkg::entry_t    rdata_b,
  output logic                out_valid,
  input  logic                out_ready,
  output rglw_pkg::id_t       out_ancestor,
  output rglw_pkg::status_t   out_status
);

  localparam int unsigned STEP_W = $clog2(STEP_LIMIT + 1);

  rglw_pkg::bk_state_t state_r, state_nxt;
  rglw_pkg::id_t       a_r, a_nxt;
  rglw_pkg::id_t       b_r, b_nxt;
  logic [STEP_W-1:0]   steps_r, steps_nxt;
  logic                out_valid_r, out_valid_nxt;
  rglw_pkg::id_t       out_anc_r, out_anc_nxt;
  rglw_pkg::status_t   out_st_r, out_st_nxt;

  logic          slot_free;
  rglw_pkg::rank_t rank_a, rank_b;
  rglw_pkg::id_t   par_a, par_b;
  logic          climb_a;

  assign slot_free = !out_valid_r || out_ready;
  assign raddr_a = a_r;
  assign raddr_b = b_r;

  // Ids outside the table read as no parent and no rank.
  always_comb begin
    rank_a = rglw_pkg::in_table(a_r, TABLE_ENTRIES) ? rdata_a.rank : rglw_pkg::NO_RANK;
    rank_b = rglw_pkg::in_table(b_r, TABLE_ENTRIES) ? rdata_b.rank : rglw_pkg::NO_RANK;
    par_a = rglw_pkg::in_table(a_r, TABLE_ENTRIES) ? rdata_a.parent : rglw_pkg::NO_PARENT;
    par_b = rglw_pkg::in_table(b_r, TABLE_ENTRIES) ? rdata_b.parent : rglw_pkg::NO_PARENT;
    climb_a = (rank_a == rglw_pkg::NO_RANK) || (rank_a > rank_b);
  end

  always_comb begin
    state_nxt = state_r;
    a_nxt = a_r;
    b_nxt = b_r;
    steps_nxt = steps_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_anc_nxt = out_anc_r;
    out_st_nxt = out_st_r;
    q_pop = 1'b0;
    tbl_wr.we = 1'b0;
    tbl_wr.waddr = q_item.node_a;
    tbl_wr.wdata.parent = q_item.parent;
    tbl_wr.wdata.rank = q_item.rank;

    case (state_r)
      rglw_pkg::BK_IDLE: begin
        if (q_valid) begin
          if (q_item.cmd == rglw_pkg::CMD_WRITE) begin
            q_pop = 1'b1;
            tbl_wr.we = q_item.wr_ok;
          end else if (slot_free) begin
            q_pop = 1'b1;
            a_nxt = q_item.node_a;
            b_nxt = q_item.node_b;
            steps_nxt = '0;
            state_nxt = rglw_pkg::BK_CHECK;
          end
        end
      end
      rglw_pkg::BK_CHECK: begin
        if (a_r == rglw_pkg::ROOT_ID || a_r == b_r) begin
          out_valid_nxt = 1'b1;
          out_anc_nxt = a_r;
          out_st_nxt = rglw_pkg::ST_OK;
          state_nxt = rglw_pkg::BK_IDLE;
        end else if (steps_r == STEP_W'(STEP_LIMIT)) begin
          out_valid_nxt = 1'b1;
          out_anc_nxt = rglw_pkg::ROOT_ID;
          out_st_nxt = rglw_pkg::ST_TIMEOUT;
          state_nxt = rglw_pkg::BK_IDLE;
        end else begin
          state_nxt = rglw_pkg::BK_STEP;
        end
      end
      rglw_pkg::BK_STEP: begin
        steps_nxt = STEP_W'(steps_r + 1'b1);
        if (climb_a) begin
          a_nxt = par_a;
        end else begin
          b_nxt = par_b;
        end
        if (a_nxt == rglw_pkg::NO_PARENT || b_nxt == rglw_pkg::NO_PARENT) begin
          out_valid_nxt = 1'b1;
          out_anc_nxt = rglw_pkg::ROOT_ID;
          out_st_nxt = rglw_pkg::ST_NO_PARENT;
          state_nxt = rglw_pkg::BK_IDLE;
        end else begin
          state_nxt = rglw_pkg::BK_CHECK;
        end
      end
      default: begin
        state_nxt = rglw_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rglw_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    steps_r <= steps_nxt;
    out_anc_r <= out_anc_nxt;
    out_st_r <= out_st_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_ancestor = out_anc_r;
  assign out_status = out_st_r;

endmodule

[sv/rank_guided_lca_walk.sv]
// Table write and lowest-common-ancestor query engine. Each write transaction is done by
// the walker once it leaves the two-entry input queue, and gives no result. A query climbs
// from parent to parent at most STEP_LIMIT times; the walk loop makes one registered read
// of the node table (both ids at once) per climb. The table has no reset and no
// clearing pass; entries read before they are written give undefined answers. The input
// queue accepts transactions, until it is full, while a walk runs or a result waits to be
// taken.
module rank_guided_lca_walk #(
  parameter int unsigned TABLE_ENTRIES = rglw_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned STEP_LIMIT = rglw_pkg::STEP_LIMIT_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  rglw_in_if.sink      in_ch,
  rglw_out_if.source   out_ch
);

  rglw_pkg::item_t   in_item;
  rglw_pkg::item_t   q_item;
  logic              q_valid;
  logic              q_pop;
  rglw_pkg::tbl_wr_t tbl_wr;
  rglw_pkg::id_t     raddr_a, raddr_b;
  rglw_pkg::entry_t  rdata_a, rdata_b;
  rglw_pkg::status_t out_status;

  always_comb begin
    in_item.cmd = rglw_pkg::cmd_t'(in_ch.cmd);
    in_item.wr_ok = 1'b0;
    in_item.node_a = in_ch.node_a;
    in_item.node_b = in_ch.node_b;
    in_item.parent = in_ch.parent_in;
    in_item.rank = in_ch.rank_in;
  end

  rglw_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  rglw_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  rglw_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .STEP_LIMIT(STEP_LIMIT)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_item       (q_item),
    .tbl_wr       (tbl_wr),
    .raddr_a      (raddr_a),
    .raddr_b      (raddr_b),
    .rdata_a      (rdata_a),
    .rdata_b      (rdata_b),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_ancestor (out_ch.ancestor),
    .out_status   (out_status)
  );

  assign out_ch.status = out_status;

  // Every error result reports the root id.
  a_err_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_status != rglw_pkg::ST_OK |-> out_ch.ancestor == rglw_pkg::ROOT_ID)
    else $error("error result without root ancestor");

  // The walker only takes items that the queue holds.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // A query starts only once the result register is free.
  a_query_slot: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_item.cmd == rglw_pkg::CMD_QUERY |=> !out_ch.valid)
    else $error("query started while a result was pending");

  // Table writes never overlap a running walk.
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_wr.we |-> q_pop && q_item.cmd == rglw_pkg::CMD_WRITE && q_item.wr_ok)
    else $error("table write outside a write transaction");

endmodule

[tb/lca_walk_checker.sv]
`timescale 1ns / 1ps

module lca_walk_checker
  import rglw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  rglw_in_if          in_ch,
  rglw_out_if         out_ch,
  output int unsigned fail_count,
  output int unsigned pending
);

  typedef struct packed {
    id_t     ancestor;
    status_t status;
  } lca_answer_t;

  id_t         parent_of[id_t];
  rank_t       rank_of[id_t];
  lca_answer_t answers_due[$];

  function automatic id_t parent_at(input id_t id);
    if (32'(id) >= TABLE_ENTRIES_DEF || !parent_of.exists(id)) begin
      return NO_PARENT;
    end
    return parent_of[id];
  endfunction

  function automatic rank_t rank_at(input id_t id);
    if (32'(id) >= TABLE_ENTRIES_DEF || !rank_of.exists(id)) begin
      return NO_RANK;
    end
    return rank_of[id];
  endfunction

  function automatic lca_answer_t lca_walk(input id_t a, input id_t b);
    lca_answer_t res;
    int unsigned climbs;
    bit          done;
    rank_t       ra;
    climbs = 0;
    done = 1'b0;
    res.ancestor = ROOT_ID;
    res.status = ST_OK;
    while (!done) begin
      if (a == ROOT_ID || a == b) begin
        res.ancestor = a;
        res.status = ST_OK;
        done = 1'b1;
      end else if (climbs >= STEP_LIMIT_DEF) begin
        res.ancestor = ROOT_ID;
        res.status = ST_TIMEOUT;
        done = 1'b1;
      end else begin
        climbs++;
        ra = rank_at(a);
        if (ra == NO_RANK || ra > rank_at(b)) begin
          a = parent_at(a);
        end else begin
          b = parent_at(b);
        end
        if (a == NO_PARENT || b == NO_PARENT) begin
          res.ancestor = ROOT_ID;
          res.status = ST_NO_PARENT;
          done = 1'b1;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    lca_answer_t due;
    if (!rst_n) begin
      answers_due.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual ancestor %0h status %0d",
                   $time, out_ch.ancestor, out_ch.status);
          fail_count++;
        end else begin
          due = answers_due.pop_front();
          if (out_ch.ancestor !== due.ancestor) begin
            $display("%0t: ancestor mismatch, expected %0h, actual %0h",
                     $time, due.ancestor, out_ch.ancestor);
            fail_count++;
          end
          if (out_ch.status !== due.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, due.status, out_ch.status);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.cmd == CMD_WRITE) begin
          if (32'(in_ch.node_a) < TABLE_ENTRIES_DEF) begin
            parent_of[in_ch.node_a] = in_ch.parent_in;
            rank_of[in_ch.node_a] = in_ch.rank_in;
          end
        end else begin
          answers_due.push_back(lca_walk(in_ch.node_a, in_ch.node_b));
        end
      end
      pending <= answers_due.size();
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import rglw_pkg::*;

  localparam int unsigned ITEM_TOTAL = 1850;
  localparam int unsigned CHAIN_LEN = STEP_LIMIT_DEF + 1;
  localparam int unsigned DRAIN_CYCLES = 2 * STEP_LIMIT_DEF + 16;
  localparam int unsigned HOLD_CYCLES = 400;

  localparam id_t ZERO_ID   = '0;
  localparam id_t N_TOP     = '1;
  localparam id_t N_EVEN    = 22'h2AAAAA;
  localparam id_t N_ODD     = 22'h155555;
  localparam id_t N_DEEP    = 22'h000002;
  localparam id_t N_LOOP    = 22'h000003;
  localparam id_t N_LEAF    = 22'h000004;
  localparam id_t N_LOST    = 22'h000005;
  localparam id_t N_ORPHAN  = 22'h3FFFFE;

  logic clk;
  logic rst_n;

  rglw_in_if  in_ch();
  rglw_out_if out_ch();

  int unsigned src_idle_pct;
  int unsigned dst_idle_pct;
  bit          stall_reader;
  int unsigned sent;
  int unsigned fail_count;
  int unsigned pending;

  id_t   known_ids[$];
  id_t   tree_ids[$];
  rank_t known_rank[id_t];

  rank_guided_lca_walk uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  lca_walk_checker walk_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial clk = 1'b0;

  always #6 clk = ~clk;

  task automatic offer(input cmd_t cmd, input id_t a, input id_t b, input id_t p,
                       input rank_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.node_a <= a;
    in_ch.node_b <= b;
    in_ch.parent_in <= p;
    in_ch.rank_in <= r;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  task automatic write_entry(input id_t id, input id_t p, input rank_t r);
    offer(CMD_WRITE, id, id_t'($urandom()), p, r);
    if (!known_rank.exists(id)) begin
      known_ids.push_back(id);
    end
    known_rank[id] = r;
  endtask

  task automatic query(input id_t a, input id_t b);
    offer(CMD_QUERY, a, b, id_t'($urandom()), rank_t'($urandom()));
  endtask

  function automatic id_t fresh_id();
    id_t n;
    do n = id_t'($urandom()); while (known_rank.exists(n));
    return n;
  endfunction

  function automatic id_t pick_known();
    return known_ids[$urandom_range(known_ids.size() - 1)];
  endfunction

  function automatic id_t pick_tree();
    return tree_ids[$urandom_range(tree_ids.size() - 1)];
  endfunction

  task automatic run_directed();
    write_entry(ZERO_ID, NO_PARENT, NO_RANK);
    write_entry(ROOT_ID, ROOT_ID, rank_t'(1));
    write_entry(N_TOP, ROOT_ID, '1);
    write_entry(N_EVEN, ROOT_ID, rank_t'(2));
    write_entry(N_ODD, N_EVEN, rank_t'(3));
    write_entry(N_DEEP, N_ODD, rank_t'(4));
    write_entry(N_ORPHAN, NO_PARENT, NO_RANK);
    write_entry(N_LOOP, N_LOOP, NO_RANK);
    write_entry(N_LOST, NO_PARENT, rank_t'(9));
    write_entry(N_LEAF, N_TOP, '1);
    query(ROOT_ID, N_TOP);
    query(N_TOP, N_TOP);
    query(ZERO_ID, ZERO_ID);
    query(N_DEEP, N_TOP);
    query(N_DEEP, N_EVEN);
    query(N_ORPHAN, N_EVEN);
    query(N_EVEN, N_ORPHAN);
    query(N_LOOP, N_EVEN);
    query(ZERO_ID, N_EVEN);
    query(N_EVEN, ZERO_ID);
    query(N_ODD, N_DEEP);
    query(N_DEEP, ROOT_ID);
    query(N_EVEN, N_LOST);
    query(N_LEAF, N_DEEP);
  endtask

  // A chain of unranked nodes below the root, so that walks of exactly the
  // step limit and of one climb more can be asked for.
  task automatic run_chain_limit();
    id_t chain[$];
    id_t p;
    id_t n;
    p = ROOT_ID;
    repeat (CHAIN_LEN) begin
      n = fresh_id();
      write_entry(n, p, NO_RANK);
      chain.push_back(n);
      p = n;
    end
    query(chain[STEP_LIMIT_DEF - 2], ZERO_ID);
    query(chain[STEP_LIMIT_DEF - 1], ZERO_ID);
    query(chain[STEP_LIMIT_DEF], ZERO_ID);
  endtask

  // Mostly rank-ordered trees hung below the root with queries inside them;
  // a smaller share rewrites entries into broken links and cycles.
  task automatic run_random(input int unsigned until_sent);
    id_t         n;
    id_t         p;
    id_t         a;
    id_t         b;
    rank_t       r;
    int unsigned pick;
    int unsigned span;
    while (sent < until_sent) begin
      pick = $urandom_range(99);
      if (tree_ids.size() == 0 || pick < 3) begin
        tree_ids.delete();
        n = fresh_id();
        write_entry(n, ROOT_ID, rank_t'(2));
        tree_ids.push_back(n);
      end else if (pick < 40) begin
        span = (tree_ids.size() > 3) ? 2 : tree_ids.size() - 1;
        if ($urandom_range(1) == 1) begin
          p = tree_ids[tree_ids.size() - 1 - $urandom_range(span)];
        end else begin
          p = pick_tree();
        end
        r = (known_rank[p] == '1) ? known_rank[p] : rank_t'(known_rank[p] + 1);
        if ($urandom_range(9) == 0) begin
          r = rank_t'($urandom_range(15));
        end
        n = fresh_id();
        write_entry(n, p, r);
        tree_ids.push_back(n);
      end else if (pick < 89) begin
        a = pick_tree();
        b = pick_tree();
        case ($urandom_range(11))
          0: a = ROOT_ID;
          1: b = ROOT_ID;
          2: b = a;
          3: a = pick_known();
          4: b = pick_known();
          5: b = ZERO_ID;
          6: a = ZERO_ID;
          default: ;
        endcase
        query(a, b);
      end else begin
        n = pick_tree();
        case ($urandom_range(3))
          0: write_entry(n, NO_PARENT, rank_t'($urandom()));
          1: write_entry(n, pick_tree(), rank_t'($urandom()));
          2: write_entry(n, n, NO_RANK);
          default: write_entry(n, pick_known(), rank_t'($urandom()));
        endcase
      end
    end
  endtask

  initial begin
    int unsigned held;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_reader) begin
        out_ch.ready <= 1'b0;
        for (held = 1; held < HOLD_CYCLES; held++) @(posedge clk);
        stall_reader = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= dst_idle_pct);
      end
    end
  end

  initial begin
    #100_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.cmd <= CMD_WRITE;
    in_ch.node_a <= '0;
    in_ch.node_b <= '0;
    in_ch.parent_in <= '0;
    in_ch.rank_in <= '0;
    sent = 0;
    stall_reader = 1'b0;
    src_idle_pct = 26;
    dst_idle_pct = 78;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    stall_reader = 1'b1;
    run_chain_limit();
    run_random(ITEM_TOTAL / 3);

    src_idle_pct = 78;
    dst_idle_pct = 26;
    stall_reader = 1'b1;
    run_random(2 * ITEM_TOTAL / 3);

    src_idle_pct = 0;
    dst_idle_pct = 0;
    stall_reader = 1'b1;
    run_random(ITEM_TOTAL);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[rank_guided_lca_walk.f]
sv/rglw_pkg.sv
sv/rglw_if.sv
sv/rglw_front.sv
sv/rglw_table.sv
sv/rglw_back.sv
sv/rank_guided_lca_walk.sv
tb/lca_walk_checker.sv
tb/tb_top.sv
